// ===== rtl/core/ptwe_pkg.sv =====
package ptwe_pkg;

   localparam int IO_BITS = 32;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic                      cmd;
      logic [IO_BITS-1:0]        virtual_address;
      logic signed [IO_BITS-1:0] write_value;
   } walk_request_type;

   typedef struct packed {
      logic                      ready;
      logic                      done;
      logic                      ok;
      logic signed [IO_BITS-1:0] read_value;
   } walk_status_type;

endpackage

// ===== rtl/core/ptwe_ram.sv =====
module ptwe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int ADDR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/ptwe_walker.sv =====
module ptwe_walker #(
   parameter int OFFSET_BITS = 4,
   parameter int TABLE_LEVELS = 2,
   parameter int FRAME_COUNT = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  ptwe_pkg::walk_request_type req,
   input  logic                       take,
   output ptwe_pkg::walk_status_type  status
);
   import ptwe_pkg::*;

   localparam int O  = OFFSET_BITS;
   localparam int L  = TABLE_LEVELS;
   localparam int FW = $clog2(FRAME_COUNT);
   localparam int FA = FW + O;
   localparam int PW = O * L;
   localparam int VB = PW + O;
   localparam int DW = (L > 1) ? $clog2(L) : 1;

   typedef enum logic [19:0] {
      ST_CLEAR    = 20'h00001,
      ST_IDLE     = 20'h00002,
      ST_T_RD     = 20'h00004,
      ST_T_CHK    = 20'h00008,
      ST_O_START  = 20'h00010,
      ST_S_RD     = 20'h00020,
      ST_S_CHK    = 20'h00040,
      ST_S_DONE   = 20'h00080,
      ST_WIPE     = 20'h00100,
      ST_V_RD     = 20'h00200,
      ST_V_CHK    = 20'h00400,
      ST_EV_RD    = 20'h00800,
      ST_EV_WR    = 20'h01000,
      ST_V_UNLINK = 20'h02000,
      ST_SET_LINK = 20'h04000,
      ST_R_RD     = 20'h08000,
      ST_R_WR     = 20'h10000,
      ST_ACC      = 20'h20000,
      ST_ACC_WAIT = 20'h40000,
      ST_DONE     = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   logic                      cmd_ff, cmd_in;
   logic [VB-1:0]             va_ff, va_in;
   logic [WORD_BITS-1:0]      wv_ff, wv_in;
   logic [DW-1:0]             lvl_ff, lvl_in;
   logic [FW-1:0]             cur_ff, cur_in;
   logic [FW-1:0]             newest_ff, newest_in;
   logic                      restore_ff, restore_in;
   logic [FA-1:0]             link_addr_ff, link_addr_in;
   logic [DW-1:0]             d_ff, d_in;
   logic [FW-1:0]             stk_frm_ff [L];
   logic [FW-1:0]             stk_frm_in [L];
   logic [O-1:0]              stk_j_ff [L];
   logic [O-1:0]              stk_j_in [L];
   logic                      stk_empty_ff [L];
   logic                      stk_empty_in [L];
   logic [FA-1:0]             stk_par_ff [L];
   logic [FA-1:0]             stk_par_in [L];
   logic [PW-1:0]             stk_vpg_ff [L];
   logic [PW-1:0]             stk_vpg_in [L];
   logic [FW-1:0]             max_ff, max_in;
   logic [PW-1:0]             best_ff, best_in;
   logic [PW-1:0]             victim_ff, victim_in;
   logic                      vvalid_ff, vvalid_in;
   logic [FW-1:0]             got_ff, got_in;
   logic [O-1:0]              cnt_ff, cnt_in;
   logic [DW-1:0]             vl_ff, vl_in;
   logic [FW-1:0]             vf_ff, vf_in;
   logic [FA-1:0]             vparent_ff, vparent_in;
   logic [VB-1:0]             clr_ff, clr_in;
   logic                      ok_ff, ok_in;
   logic signed [IO_BITS-1:0] rv_ff, rv_in;

   logic                 fm_we;
   logic [FA-1:0]        fm_waddr, fm_raddr;
   logic [WORD_BITS-1:0] fm_wdata, fm_rdata;
   logic                 sw_we;
   logic [VB-1:0]        sw_waddr, sw_raddr;
   logic [WORD_BITS-1:0] sw_wdata, sw_rdata;

   ptwe_ram #(
      .WIDTH(WORD_BITS), .DEPTH(FRAME_COUNT << O), .ADDR_BITS(FA)
   ) u_frame_ram (
      .clock(clock), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
      .raddr(fm_raddr), .rdata(fm_rdata)
   );

   ptwe_ram #(
      .WIDTH(WORD_BITS), .DEPTH(1 << VB), .ADDR_BITS(VB)
   ) u_swap_ram (
      .clock(clock), .we(sw_we), .waddr(sw_waddr), .wdata(sw_wdata),
      .raddr(sw_raddr), .rdata(sw_rdata)
   );

   function automatic logic [FW-1:0] link_of(input logic [WORD_BITS-1:0] v);
      return (v < WORD_BITS'(FRAME_COUNT)) ? FW'(v) : '0;
   endfunction

   function automatic logic [O-1:0] idx_of(input logic [PW-1:0] pg, input logic [DW-1:0] lv);
      logic [O-1:0] r;
      r = '0;
      for (int i = 0; i < L; i++) begin
         if (lv == DW'(i)) begin
            r = pg[(L-1-i)*O +: O];
         end
      end
      return r;
   endfunction

   function automatic logic [PW-1:0] dist_of(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW-1:0] dd;
      logic [PW:0]   alt;
      dd  = (a > b) ? a - b : b - a;
      alt = {1'b1, {PW{1'b0}}} - {1'b0, dd};
      return (alt < {1'b0, dd}) ? alt[PW-1:0] : dd;
   endfunction

   wire [PW-1:0] page = va_ff[VB-1:O];
   wire [O-1:0]  off  = va_ff[O-1:0];

   always_comb begin
      logic [FW-1:0] child;
      logic [PW-1:0] cvpg;
      logic [PW-1:0] cdist;
      logic [FA-1:0] caddr;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      va_in        = va_ff;
      wv_in        = wv_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      newest_in    = newest_ff;
      restore_in   = restore_ff;
      link_addr_in = link_addr_ff;
      d_in         = d_ff;
      stk_frm_in   = stk_frm_ff;
      stk_j_in     = stk_j_ff;
      stk_empty_in = stk_empty_ff;
      stk_par_in   = stk_par_ff;
      stk_vpg_in   = stk_vpg_ff;
      max_in       = max_ff;
      best_in      = best_ff;
      victim_in    = victim_ff;
      vvalid_in    = vvalid_ff;
      got_in       = got_ff;
      cnt_in       = cnt_ff;
      vl_in        = vl_ff;
      vf_in        = vf_ff;
      vparent_in   = vparent_ff;
      clr_in       = clr_ff;
      ok_in        = ok_ff;
      rv_in        = rv_ff;

      fm_we    = 1'b0;
      fm_waddr = '0;
      fm_wdata = '0;
      fm_raddr = '0;
      sw_we    = 1'b0;
      sw_waddr = '0;
      sw_wdata = '0;
      sw_raddr = '0;

      child = link_of(fm_rdata);
      caddr = {stk_frm_ff[d_ff], stk_j_ff[d_ff]};
      cvpg  = PW'({stk_vpg_ff[d_ff], stk_j_ff[d_ff]});
      cdist = dist_of(page, cvpg);

      case (state_ff)
         ST_CLEAR: begin
            sw_we    = 1'b1;
            sw_waddr = clr_ff;
            if (clr_ff[VB-1:O] == '0) begin
               fm_we    = 1'b1;
               fm_waddr = FA'(clr_ff[O-1:0]);
            end
            clr_in = clr_ff + VB'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if ((64'(req.virtual_address) >> VB) != 64'd0) begin
                  ok_in    = 1'b0;
                  rv_in    = '0;
                  state_in = ST_DONE;
               end else begin
                  cmd_in     = req.cmd;
                  va_in      = VB'(req.virtual_address);
                  wv_in      = WORD_BITS'(req.write_value);
                  lvl_in     = '0;
                  cur_in     = '0;
                  newest_in  = '0;
                  restore_in = 1'b0;
                  state_in   = ST_T_RD;
               end
            end
         end
         ST_T_RD: begin
            fm_raddr     = {cur_ff, idx_of(page, lvl_ff)};
            link_addr_in = {cur_ff, idx_of(page, lvl_ff)};
            state_in     = ST_T_CHK;
         end
         ST_T_CHK: begin
            if (child != '0) begin
               cur_in = child;
               cnt_in = '0;
               if (lvl_ff == DW'(L-1)) begin
                  state_in = restore_ff ? ST_R_RD : ST_ACC;
               end else begin
                  lvl_in   = lvl_ff + DW'(1);
                  state_in = ST_T_RD;
               end
            end else begin
               restore_in = 1'b1;
               state_in   = ST_O_START;
            end
         end
         ST_O_START: begin
            d_in            = '0;
            stk_frm_in[0]   = '0;
            stk_j_in[0]     = '0;
            stk_empty_in[0] = 1'b1;
            stk_par_in[0]   = '0;
            stk_vpg_in[0]   = '0;
            max_in          = '0;
            best_in         = '0;
            victim_in       = '0;
            vvalid_in       = 1'b0;
            state_in        = ST_S_RD;
         end
         ST_S_RD: begin
            fm_raddr = caddr;
            state_in = ST_S_CHK;
         end
         ST_S_CHK: begin
            if (child != '0 && d_ff != DW'(L-1)) begin
               stk_empty_in[d_ff]      = 1'b0;
               stk_frm_in[d_ff+DW'(1)]   = child;
               stk_j_in[d_ff+DW'(1)]     = '0;
               stk_empty_in[d_ff+DW'(1)] = 1'b1;
               stk_par_in[d_ff+DW'(1)]   = caddr;
               stk_vpg_in[d_ff+DW'(1)]   = cvpg;
               d_in = d_ff + DW'(1);
               if (child > max_ff) begin
                  max_in = child;
               end
               state_in = ST_S_RD;
            end else begin
               if (child != '0) begin
                  stk_empty_in[d_ff] = 1'b0;
                  if (child > max_ff) begin
                     max_in = child;
                  end
                  if (cdist > best_ff) begin
                     best_in   = cdist;
                     victim_in = cvpg;
                     vvalid_in = 1'b1;
                  end
               end
               if (&stk_j_ff[d_ff]) begin
                  state_in = ST_S_DONE;
               end else begin
                  stk_j_in[d_ff] = stk_j_ff[d_ff] + O'(1);
                  state_in       = ST_S_RD;
               end
            end
         end
         ST_S_DONE: begin
            if (stk_empty_ff[d_ff] && stk_frm_ff[d_ff] != newest_ff &&
                stk_frm_ff[d_ff] != '0) begin
               fm_we    = 1'b1;
               fm_waddr = stk_par_ff[d_ff];
               got_in   = stk_frm_ff[d_ff];
               state_in = ST_SET_LINK;
            end else if (d_ff == '0) begin
               cnt_in = '0;
               if (({1'b0, max_ff} + (FW+1)'(1)) < (FW+1)'(FRAME_COUNT)) begin
                  got_in   = max_ff + FW'(1);
                  state_in = ST_WIPE;
               end else if (!vvalid_ff) begin
                  ok_in    = 1'b0;
                  rv_in    = '0;
                  state_in = ST_DONE;
               end else begin
                  vl_in    = '0;
                  vf_in    = '0;
                  state_in = ST_V_RD;
               end
            end else begin
               d_in = d_ff - DW'(1);
               if (&stk_j_ff[d_ff-DW'(1)]) begin
                  state_in = ST_S_DONE;
               end else begin
                  stk_j_in[d_ff-DW'(1)] = stk_j_ff[d_ff-DW'(1)] + O'(1);
                  state_in = ST_S_RD;
               end
            end
         end
         ST_WIPE: begin
            fm_we    = 1'b1;
            fm_waddr = {got_ff, cnt_ff};
            cnt_in   = cnt_ff + O'(1);
            if (&cnt_ff) begin
               state_in = ST_SET_LINK;
            end
         end
         ST_V_RD: begin
            fm_raddr   = {vf_ff, idx_of(victim_ff, vl_ff)};
            vparent_in = {vf_ff, idx_of(victim_ff, vl_ff)};
            state_in   = ST_V_CHK;
         end
         ST_V_CHK: begin
            if (child == '0) begin
               ok_in    = 1'b0;
               rv_in    = '0;
               state_in = ST_DONE;
            end else begin
               vf_in = child;
               if (vl_ff == DW'(L-1)) begin
                  cnt_in   = '0;
                  state_in = ST_EV_RD;
               end else begin
                  vl_in    = vl_ff + DW'(1);
                  state_in = ST_V_RD;
               end
            end
         end
         ST_EV_RD: begin
            fm_raddr = {vf_ff, cnt_ff};
            state_in = ST_EV_WR;
         end
         ST_EV_WR: begin
            sw_we    = 1'b1;
            sw_waddr = {victim_ff, cnt_ff};
            sw_wdata = fm_rdata;
            fm_we    = 1'b1;
            fm_waddr = {vf_ff, cnt_ff};
            cnt_in   = cnt_ff + O'(1);
            state_in = (&cnt_ff) ? ST_V_UNLINK : ST_EV_RD;
         end
         ST_V_UNLINK: begin
            fm_we    = 1'b1;
            fm_waddr = vparent_ff;
            got_in   = vf_ff;
            state_in = ST_SET_LINK;
         end
         ST_SET_LINK: begin
            fm_we     = 1'b1;
            fm_waddr  = link_addr_ff;
            fm_wdata  = WORD_BITS'(got_ff);
            newest_in = got_ff;
            cur_in    = got_ff;
            cnt_in    = '0;
            if (lvl_ff == DW'(L-1)) begin
               state_in = ST_R_RD;
            end else begin
               lvl_in   = lvl_ff + DW'(1);
               state_in = ST_T_RD;
            end
         end
         ST_R_RD: begin
            sw_raddr = {page, cnt_ff};
            state_in = ST_R_WR;
         end
         ST_R_WR: begin
            fm_we    = 1'b1;
            fm_waddr = {cur_ff, cnt_ff};
            fm_wdata = sw_rdata;
            cnt_in   = cnt_ff + O'(1);
            state_in = (&cnt_ff) ? ST_ACC : ST_R_RD;
         end
         ST_ACC: begin
            if (cmd_ff == CMD_WRITE) begin
               fm_we    = 1'b1;
               fm_waddr = {cur_ff, off};
               fm_wdata = wv_ff;
               ok_in    = 1'b1;
               rv_in    = '0;
               state_in = ST_DONE;
            end else begin
               fm_raddr = {cur_ff, off};
               state_in = ST_ACC_WAIT;
            end
         end
         ST_ACC_WAIT: begin
            ok_in    = 1'b1;
            rv_in    = IO_BITS'(signed'(fm_rdata));
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      cmd_ff       <= cmd_in;
      va_ff        <= va_in;
      wv_ff        <= wv_in;
      lvl_ff       <= lvl_in;
      cur_ff       <= cur_in;
      newest_ff    <= newest_in;
      restore_ff   <= restore_in;
      link_addr_ff <= link_addr_in;
      d_ff         <= d_in;
      stk_frm_ff   <= stk_frm_in;
      stk_j_ff     <= stk_j_in;
      stk_empty_ff <= stk_empty_in;
      stk_par_ff   <= stk_par_in;
      stk_vpg_ff   <= stk_vpg_in;
      max_ff       <= max_in;
      best_ff      <= best_in;
      victim_ff    <= victim_in;
      vvalid_ff    <= vvalid_in;
      got_ff       <= got_in;
      cnt_ff       <= cnt_in;
      vl_ff        <= vl_in;
      vf_ff        <= vf_in;
      vparent_ff   <= vparent_in;
      ok_ff        <= ok_in;
      rv_ff        <= rv_in;
   end

   assign status.ready      = (state_ff == ST_IDLE);
   assign status.done       = (state_ff == ST_DONE);
   assign status.ok         = ok_ff;
   assign status.read_value = rv_ff;

endmodule

// ===== rtl/core/paged_translation_with_eviction.sv =====
// Paged virtual memory: one word read or written per request beat, through a page table of
// TABLE_LEVELS levels kept in a single-port-read frame RAM, with demand frame allocation and
// eviction of the farthest mapped page to a swap RAM. After reset a clearing pass writes the
// whole swap RAM, 2^(OFFSET_BITS*(TABLE_LEVELS+1)) words (4096 by default), during which
// req_ready stays low. An access whose walk hits reads one table entry per level, then reads
// or writes the data word. A miss adds a depth-first scan of the table tree, then either the
// reuse of an emptied table frame, a frame wipe or a victim walk plus a page copy-out, and
// finally a page restore from swap. One request is in flight at a time; a finished response
// sits in an output register so the next request is taken while it waits for rsp_ready.
module paged_translation_with_eviction #(
   parameter int OFFSET_BITS = 4,
   parameter int TABLE_LEVELS = 2,
   parameter int FRAME_COUNT = 16,
   parameter int WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [31:0]        req_virtual_address,
   input  logic signed [31:0] req_write_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_ok
);
   import ptwe_pkg::*;

   walk_request_type walk_req;
   walk_status_type  walk_stat;
   logic             take;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_ok_ff, rsp_ok_in;
   logic signed [IO_BITS-1:0] rsp_rv_ff, rsp_rv_in;

   assign walk_req.cmd             = req_cmd;
   assign walk_req.virtual_address = req_virtual_address;
   assign walk_req.write_value     = req_write_value;

   assign take = !rsp_valid_ff || rsp_ready;

   ptwe_walker #(
      .OFFSET_BITS(OFFSET_BITS), .TABLE_LEVELS(TABLE_LEVELS),
      .FRAME_COUNT(FRAME_COUNT), .WORD_BITS(WORD_BITS)
   ) u_walker (
      .clock(clock), .reset(reset),
      .start(req_valid && walk_stat.ready), .req(walk_req),
      .take(take), .status(walk_stat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_rv_in    = rsp_rv_ff;
      if (walk_stat.done && take) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = walk_stat.ok;
         rsp_rv_in    = walk_stat.read_value;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff <= rsp_ok_in;
      rsp_rv_ff <= rsp_rv_in;
   end

   assign req_ready      = walk_stat.ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_rv_ff;

endmodule
